### src/tpsd_pkg.sv
// Package for the TGA pixel stream decoder.
// Holds register indexes, format codes, constants and the structs shared by
// the front, queue, back and top level. No dependencies.
package tpsd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        CFG_PIXEL_FORMAT = 2'd0,
        CFG_RUN_LENGTH   = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } t_cfg_idx;

    localparam logic [1:0] FMT_GRAY  = 2'd0;
    localparam logic [1:0] FMT_BGR   = 2'd1;
    localparam logic [1:0] FMT_BGRA  = 2'd2;
    localparam logic [1:0] FMT_SPARE = 2'd3;

    localparam logic [7:0] HDR_REPEAT   = 8'd128;
    localparam logic [7:0] REPEAT_BIAS  = 8'd127;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // one parsed byte, front to back
    typedef struct packed {
        logic       restart;
        logic       pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       is_repeat;
        logic [7:0] run;
        logic       lit_more;
    } t_item;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [31:0] pixel_index;
        logic [7:0]  run_count;
        logic        last;
        logic        clipped;
    } t_result;

endpackage

### src/tpsd_front.sv
// Byte parser of the TGA pixel stream decoder: packet headers, byte gathering
// and channel mapping. Emits one t_item per accepted byte. Uses tpsd_pkg.
module tpsd_front import tpsd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic       i_full,
    input  logic [1:0] i_format,
    input  logic       i_rlc,
    output logic       o_ready,
    output logic       o_push,
    output t_item      o_item
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_left, n_left;
    logic       r_is_repeat, n_is_repeat;
    logic [7:0] r_gath [3];
    logic [7:0] n_gath [3];

    logic       w_accept;
    logic [1:0] w_phase;
    logic [7:0] w_left;
    logic       w_rep;
    logic [7:0] w_gath [3];
    logic [2:0] w_bpp;
    logic       w_header;
    logic       w_gather;
    logic [1:0] w_idx;
    logic       w_rep_run;
    logic [7:0] w_left_dec;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;

    always_comb begin
        w_phase = i_start ? 2'd0 : r_phase;
        w_left  = i_start ? 8'd0 : r_left;
        w_rep   = i_start ? 1'b0 : r_is_repeat;
        for (int k = 0; k < 3; k++) begin
            w_gath[k] = i_start ? 8'd0 : r_gath[k];
        end

        case (i_format)
            FMT_GRAY: w_bpp = 3'd1;
            FMT_BGR:  w_bpp = 3'd3;
            default:  w_bpp = 3'd4;
        endcase

        w_header   = i_rlc && (w_left == 8'd0) && (w_phase == 2'd0);
        w_gather   = ({1'b0, w_phase} + 3'd1) < w_bpp;
        w_idx      = w_phase[0] ? 2'd1 : ((w_phase >= 2'd2) ? 2'd2 : 2'd0);
        w_rep_run  = i_rlc && w_rep;
        w_left_dec = w_left - 8'd1;

        n_phase     = w_phase;
        n_left      = w_left;
        n_is_repeat = w_rep;
        for (int k = 0; k < 3; k++) begin
            n_gath[k] = w_gath[k];
        end

        o_item           = '0;
        o_item.restart   = i_start;
        o_item.is_repeat = w_rep_run;
        o_item.run       = w_rep_run ? w_left : 8'd1;
        o_item.lit_more  = !w_rep_run && i_rlc && (w_left_dec != 8'd0);

        unique case (i_format)
            FMT_GRAY: begin
                o_item.red   = i_byte;
                o_item.green = i_byte;
                o_item.blue  = i_byte;
                o_item.alpha = ALPHA_OPAQUE;
            end
            FMT_BGR: begin
                o_item.blue  = w_gath[0];
                o_item.green = w_gath[1];
                o_item.red   = i_byte;
                o_item.alpha = ALPHA_OPAQUE;
            end
            default: begin
                o_item.blue  = w_gath[0];
                o_item.green = w_gath[1];
                o_item.red   = w_gath[2];
                o_item.alpha = i_byte;
            end
        endcase

        if (w_header) begin
            if (i_byte < HDR_REPEAT) begin
                n_left      = i_byte + 8'd1;
                n_is_repeat = 1'b0;
            end else begin
                n_left      = i_byte - REPEAT_BIAS;
                n_is_repeat = 1'b1;
            end
        end else if (w_gather) begin
            n_gath[w_idx] = i_byte;
            n_phase       = w_phase + 2'd1;
        end else begin
            o_item.pixel = 1'b1;
            n_phase      = 2'd0;
            if (w_rep_run) begin
                n_left = 8'd0;
            end else if (i_rlc) begin
                n_left = w_left_dec;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 2'd0;
            r_left      <= 8'd0;
            r_is_repeat <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_gath[k] <= 8'd0;
            end
        end else if (w_accept) begin
            r_phase     <= n_phase;
            r_left      <= n_left;
            r_is_repeat <= n_is_repeat;
            for (int k = 0; k < 3; k++) begin
                r_gath[k] <= n_gath[k];
            end
        end
    end

endmodule

### src/tpsd_queue.sv
// Short queue of parsed items between front and back of the decoder.
// Depth set by QUEUE_DEPTH in tpsd_pkg.
module tpsd_queue import tpsd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01:   r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### src/tpsd_back.sv
// Pixel counter and result stage of the decoder: image end, run clipping,
// pixel index and the output register. Uses tpsd_pkg.
module tpsd_back import tpsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    input  logic [31:0] i_total,
    input  logic        i_m_ready,
    output logic        o_pop,
    output logic        o_valid,
    output t_result     o_result
);

    logic [31:0] r_pd, n_pd;
    logic        r_fin, n_fin;
    logic        r_out_valid;
    t_result     r_out;

    logic [31:0] w_pd;
    logic        w_fin;
    logic        w_has_result;
    logic        w_out_free;
    logic [7:0]  w_run;
    logic [32:0] w_sum;
    logic [32:0] w_tot;
    logic [31:0] w_diff;
    logic        w_clip_rep;
    logic        w_clip_lit;
    logic        w_last;
    t_result     w_res;

    always_comb begin
        w_pd         = i_item.restart ? 32'd0 : r_pd;
        w_fin        = (i_item.restart ? 1'b0 : r_fin) | (w_pd >= i_total);
        w_has_result = i_valid && i_item.pixel && !w_fin;
        w_out_free   = !r_out_valid || i_m_ready;
        o_pop        = i_valid && (!w_has_result || w_out_free);

        w_run      = i_item.is_repeat ? i_item.run : 8'd1;
        w_sum      = {1'b0, w_pd} + {25'd0, w_run};
        w_tot      = {1'b0, i_total};
        w_diff     = i_total - w_pd;
        w_clip_rep = i_item.is_repeat && (w_sum > w_tot);
        w_clip_lit = !i_item.is_repeat && i_item.lit_more && (w_sum == w_tot);
        w_last     = (w_sum >= w_tot);

        w_res.red         = i_item.red;
        w_res.green       = i_item.green;
        w_res.blue        = i_item.blue;
        w_res.alpha       = i_item.alpha;
        w_res.pixel_index = w_pd;
        w_res.run_count   = w_clip_rep ? w_diff[7:0] : w_run;
        w_res.last        = w_last;
        w_res.clipped     = w_clip_rep || w_clip_lit;

        n_pd  = r_pd;
        n_fin = r_fin;
        if (o_pop) begin
            if (w_has_result) begin
                n_pd  = w_clip_rep ? i_total : w_sum[31:0];
                n_fin = w_last;
            end else begin
                n_pd  = w_pd;
                n_fin = w_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pd        <= 32'd0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pd  <= n_pd;
            r_fin <= n_fin;
            if (o_pop && w_has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_has_result) begin
            r_out <= w_res;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_has_result) |-> w_out_free)
        else $error("result loaded over a pending transaction");

    a_last_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && w_has_result && w_last) |=> r_fin)
        else $error("image end not recorded after last run");

    a_clip_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.clipped) |-> r_out.last)
        else $error("clipped run does not end the image");
`endif

endmodule

### src/tga_pixel_stream_decoder_unit.sv
// Top level of the TGA pixel stream decoder: configuration registers and the
// front parser, item queue and back result stage. Uses tpsd_pkg.
//
// Takes one byte of the TGA pixel data section per transaction and returns
// RGBA runs. The input side takes a byte in every cycle while the four-entry
// queue between parser and result stage has room. After its final byte a
// result passes the queue and then the output register, which holds it while
// the downstream side stalls. One byte per cycle is sustained while results
// are taken downstream, limited by one queue pop per cycle in the result
// stage. Image size (width times height) is computed when either is written.
module tga_pixel_stream_decoder_unit import tpsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic        i_s_tuser,   // start_of_image
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // red, green, blue, alpha, pixel_index, run_count
    output logic        o_m_tlast,   // last
    output logic        o_m_tuser    // clipped
);

    logic [1:0]  r_format;
    logic        r_rlc;
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [31:0] r_total;

    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_q_valid;
    t_item       w_front_item;
    t_item       w_back_item;
    t_result     w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_BGRA;
            r_rlc    <= 1'b0;
            r_width  <= 16'd1;
            r_height <= 16'd1;
            r_total  <= 32'd1;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_PIXEL_FORMAT: r_format <= i_cfg_wdata[1:0];
                CFG_RUN_LENGTH:   r_rlc    <= i_cfg_wdata[0];
                CFG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_wdata;
                    r_total <= {16'd0, i_cfg_wdata} * {16'd0, r_height};
                end
                CFG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_wdata;
                    r_total  <= {16'd0, r_width} * {16'd0, i_cfg_wdata};
                end
                default: r_rlc <= r_rlc;
            endcase
        end
    end

    tpsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .i_byte   (i_s_tdata),
        .i_start  (i_s_tuser),
        .i_full   (w_full),
        .i_format (r_format),
        .i_rlc    (r_rlc),
        .o_ready  (o_s_tready),
        .o_push   (w_push),
        .o_item   (w_front_item)
    );

    tpsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_back_item)
    );

    tpsd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .i_item    (w_back_item),
        .i_total   (r_total),
        .i_m_ready (i_m_tready),
        .o_pop     (w_pop),
        .o_valid   (o_m_tvalid),
        .o_result  (w_result)
    );

    assign o_m_tdata = {w_result.run_count, w_result.pixel_index, w_result.alpha,
                        w_result.blue, w_result.green, w_result.red};
    assign o_m_tlast = w_result.last;
    assign o_m_tuser = w_result.clipped;

endmodule
